/* rtl/core/hslxyz_pkg.sv */
// Package for the HSL to CIE XYZ converter: widths, constants, matrix and hue helpers.
`default_nettype none

package hslxyz_pkg;

  // Fraction bits of the RGB-to-XYZ matrix coefficients.
  localparam int FRAC_BITS = 16;

  localparam int HUE_W     = 15;
  localparam int CH_W      = 17;
  localparam int LVL_W     = 17;
  localparam int WGT_W     = 12;
  localparam int LS_W      = 2 * CH_W;
  localparam int ONE_SHIFT = 16;

  // Ramp: round(d * w / 3840) = floor((d * w + 1920) / 256 / 15), the last step
  // by a reciprocal multiply that is exact over the range of the quotient.
  localparam int PRD_W       = LVL_W + WGT_W;
  localparam int RAMP_SHIFT  = 8;
  localparam int RAMP_Y_W    = PRD_W + 1 - RAMP_SHIFT;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 23;
  localparam int RAMP_M_W    = RAMP_Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'((64'd1 << RECIP_SHIFT) / 15 + 1);

  localparam int COEF_W = FRAC_BITS;
  localparam int MAC_W  = COEF_W + LVL_W;
  localparam int ACC_W  = MAC_W + 2;
  localparam int SH_W   = ACC_W - FRAC_BITS;

  localparam int NUM_STG = 8;

  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [WGT_W-1:0]  wgt_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [MAC_W-1:0]  mac_t;

  localparam chan_t ONE      = 17'd65536;
  localparam chan_t HALF_ONE = 17'd32768;
  localparam chan_t OUT_MAX  = 17'd131071;

  localparam hue_t HUE_FULL = 15'd23040;
  localparam hue_t HUE_60   = 15'd3840;
  localparam hue_t HUE_120  = 15'd7680;
  localparam hue_t HUE_180  = 15'd11520;
  localparam hue_t HUE_240  = 15'd15360;

  // Rows give X, Y and Z; columns weight R, G and B. Each value is rounded to
  // nearest with halves up.
  localparam coef_t COEF [3][3] = '{
    '{coef_t'(((64'd430574 << FRAC_BITS) + 64'd500000) / 64'd1000000),
      coef_t'(((64'd341550 << FRAC_BITS) + 64'd500000) / 64'd1000000),
      coef_t'(((64'd178325 << FRAC_BITS) + 64'd500000) / 64'd1000000)},
    '{coef_t'(((64'd222015 << FRAC_BITS) + 64'd500000) / 64'd1000000),
      coef_t'(((64'd706655 << FRAC_BITS) + 64'd500000) / 64'd1000000),
      coef_t'(((64'd71330  << FRAC_BITS) + 64'd500000) / 64'd1000000)},
    '{coef_t'(((64'd20183  << FRAC_BITS) + 64'd500000) / 64'd1000000),
      coef_t'(((64'd129553 << FRAC_BITS) + 64'd500000) / 64'd1000000),
      coef_t'(((64'd939180 << FRAC_BITS) + 64'd500000) / 64'd1000000)}
  };

  // Load strobes for the three register stages of a ramp channel.
  typedef struct packed {
    logic load_prod;
    logic load_scale;
    logic load_level;
  } ramp_en_t;

  // Adds a hue offset and wraps the sum into one turn.
  function automatic hue_t hue_add(input hue_t h, input hue_t offset);
    logic [HUE_W:0] total;
    total = {1'b0, h} + {1'b0, offset};
    if (total >= {1'b0, HUE_FULL}) begin
      total = total - {1'b0, HUE_FULL};
    end
    return total[HUE_W-1:0];
  endfunction

  // Weight of the upper level, in 1/3840 steps, for a wrapped channel hue.
  function automatic wgt_t hue_weight(input hue_t a);
    wgt_t w;
    priority if (a < HUE_60) begin
      w = a[WGT_W-1:0];
    end else if (a < HUE_180) begin
      w = HUE_60[WGT_W-1:0];
    end else if (a < HUE_240) begin
      w = WGT_W'(HUE_240 - a);
    end else begin
      w = '0;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hslxyz_if.sv */
// Handshake interfaces for the HSL pixel channel and the XYZ result channel.
`default_nettype none

interface hslxyz_hsl_if;
  import hslxyz_pkg::*;
  logic  valid;
  logic  ready;
  hue_t  hue;
  chan_t saturation;
  chan_t lightness;
  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink (input valid, hue, saturation, lightness, output ready);
endinterface

interface hslxyz_xyz_if;
  import hslxyz_pkg::*;
  logic  valid;
  logic  ready;
  chan_t x_value;
  chan_t y_value;
  chan_t z_value;
  logic  range_error;
  modport source (output valid, x_value, y_value, z_value, range_error, input ready);
  modport sink (input valid, x_value, y_value, z_value, range_error, output ready);
endinterface

`default_nettype wire

/* rtl/core/hsl_to_xyz_converter_unit.sv */
// Top level of the HSL to CIE XYZ converter: eight-stage pixel pipeline.
//
// Usage. Pixels arrive on the hsl channel (hue in 1/64 degree, saturation and
// lightness in Q1.16, at most 1.0) and results leave on the xyz channel (X, Y, Z in Q1.16
// plus a range error flag). An item moves on a channel at a rising clock edge
// at which valid and ready are both high.
//
// The pipeline has eight register stages; a result is offered from the last of them
// and leaves at an edge at which xyz is ready. Unless a stall has filled every
// stage, the pipeline takes one item in every cycle. The multipliers of each stage
// (level product, ramp weight, reciprocal scaling, matrix products) each sit
// between registers of their own, which sets the depth of eight stages.
//
// Each stage has a valid bit and loads when it is empty or when the stage after
// it moves on, so a stalled receiver holds the result in the output register
// while empty stages upstream still fill; ready on hsl falls only once every
// stage holds an item. Nothing is dropped or repeated under a stall.
//
// Synchronous reset clears all valid bits; no item is in flight afterwards.
// An input beyond its valid range gives zero outputs with range_error set.
`default_nettype none

module hsl_to_xyz_converter_unit (
  input  logic   clk,
  input  logic   rst,
  hslxyz_hsl_if.sink   hsl,
  hslxyz_xyz_if.source xyz
);
  import hslxyz_pkg::*;

  logic [NUM_STG:1] vld;
  logic [NUM_STG:1] ena;

  // Stage 1: range check, hue wrap and the lightness-saturation product.
  logic             s1_err;
  hue_t             s1_hue;
  chan_t            s1_sat;
  chan_t            s1_light;
  logic [LS_W-1:0]  s1_prod;

  // Stage 2: upper level and channel weights.
  logic             s2_err;
  chan_t            s2_light;
  lvl_t             s2_t2;
  wgt_t             s2_wgt [3];

  // Stage 3: lower level and level difference.
  logic             s3_err;
  lvl_t             s3_t1;
  lvl_t             s3_d;
  wgt_t             s3_wgt [3];

  // Stages 4 to 6 live in the ramp channels; the error flag travels alongside.
  logic             s4_err;
  logic             s5_err;
  logic             s6_err;
  lvl_t             lvl [3];
  ramp_en_t         ramp_en;

  // Stage 7: matrix products; stage 8: sums, rounding and saturation.
  logic             s7_err;
  mac_t             s7_prod [3][3];
  logic             s8_err;
  chan_t            s8_xyz [3];

  logic [LS_W:0]    p_full;
  chan_t            p;
  logic [CH_W:0]    t2_calc;
  logic [CH_W:0]    two_l;
  lvl_t             t1_calc;
  lvl_t             t2_max;
  logic [ACC_W-1:0] acc [3];
  logic [SH_W-1:0]  acc_sh [3];

  // A stage may load when it is empty or when its contents move on.
  always_comb begin
    ena[NUM_STG] = !vld[NUM_STG] || xyz.ready;
    for (int k = NUM_STG - 1; k >= 1; k--) begin
      ena[k] = !vld[k] || ena[k+1];
    end
  end

  assign hsl.ready = ena[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ena[1]) begin
        vld[1] <= hsl.valid;
      end
      for (int k = 2; k <= NUM_STG; k++) begin
        if (ena[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    if (ena[1]) begin
      s1_err   <= (hsl.hue > HUE_FULL) || (hsl.saturation > ONE) || (hsl.lightness > ONE);
      s1_hue   <= (hsl.hue >= HUE_FULL) ? hsl.hue - HUE_FULL : hsl.hue;
      s1_sat   <= hsl.saturation;
      s1_light <= hsl.lightness;
      s1_prod  <= {{CH_W{1'b0}}, hsl.lightness} * {{CH_W{1'b0}}, hsl.saturation};
    end
  end

  // Stage 2: the product rounded half up, then the upper level. Zero
  // saturation needs no special handling: both levels come out at lightness.
  always_comb begin
    p_full = ({1'b0, s1_prod} + (LS_W + 1)'(HALF_ONE)) >> ONE_SHIFT;
    p      = p_full[CH_W-1:0];
    if (s1_light <= HALF_ONE) begin
      t2_calc = {1'b0, s1_light} + {1'b0, p};
    end else begin
      t2_calc = {1'b0, s1_light} + {1'b0, s1_sat} - {1'b0, p};
    end
  end

  always_ff @(posedge clk) begin
    if (ena[2]) begin
      s2_err    <= s1_err;
      s2_light  <= s1_light;
      s2_t2     <= t2_calc[LVL_W-1:0];
      s2_wgt[0] <= hue_weight(hue_add(s1_hue, HUE_120));
      s2_wgt[1] <= hue_weight(s1_hue);
      s2_wgt[2] <= hue_weight(hue_add(s1_hue, HUE_240));
    end
  end

  // Stage 3: lower level clamped at zero, the upper level kept at or above it.
  always_comb begin
    two_l   = {s2_light, 1'b0};
    t1_calc = (two_l > {1'b0, s2_t2}) ? LVL_W'(two_l - {1'b0, s2_t2}) : '0;
    t2_max  = (s2_t2 < t1_calc) ? t1_calc : s2_t2;
  end

  always_ff @(posedge clk) begin
    if (ena[3]) begin
      s3_err <= s2_err;
      s3_t1  <= t1_calc;
      s3_d   <= t2_max - t1_calc;
      s3_wgt <= s2_wgt;
    end
  end

  // Stages 4 to 6: one ramp per channel, R, G and B.
  assign ramp_en = '{load_prod: ena[4], load_scale: ena[5], load_level: ena[6]};

  for (genvar ch = 0; ch < 3; ch++) begin : g_ramp
    hslxyz_ramp u_ramp (
      .clk   (clk),
      .en    (ramp_en),
      .t1    (s3_t1),
      .d     (s3_d),
      .wgt   (s3_wgt[ch]),
      .level (lvl[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (ena[4]) begin
      s4_err <= s3_err;
    end
    if (ena[5]) begin
      s5_err <= s4_err;
    end
    if (ena[6]) begin
      s6_err <= s5_err;
    end
  end

  // Stage 7: the nine coefficient products.
  always_ff @(posedge clk) begin
    if (ena[7]) begin
      s7_err <= s6_err;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s7_prod[i][j] <= {{LVL_W{1'b0}}, COEF[i][j]} * {{COEF_W{1'b0}}, lvl[j]};
        end
      end
    end
  end

  // Stage 8: row sums, rounding half up, saturation and the error override.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]    = ACC_W'(s7_prod[i][0]) + ACC_W'(s7_prod[i][1]) + ACC_W'(s7_prod[i][2])
                + (ACC_W'(1) << (FRAC_BITS - 1));
      acc_sh[i] = SH_W'(acc[i] >> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (ena[8]) begin
      s8_err <= s7_err;
      for (int i = 0; i < 3; i++) begin
        if (s7_err) begin
          s8_xyz[i] <= '0;
        end else if (acc_sh[i] > SH_W'(OUT_MAX)) begin
          s8_xyz[i] <= OUT_MAX;
        end else begin
          s8_xyz[i] <= acc_sh[i][CH_W-1:0];
        end
      end
    end
  end

  assign xyz.valid       = vld[NUM_STG];
  assign xyz.x_value     = s8_xyz[0];
  assign xyz.y_value     = s8_xyz[1];
  assign xyz.z_value     = s8_xyz[2];
  assign xyz.range_error = s8_err;

  // With the output register empty every stage can load, so input is taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !xyz.valid |-> hsl.ready)
    else $error("hsl.ready low while the output register is empty");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    xyz.valid && xyz.range_error |->
      (xyz.x_value == '0) && (xyz.y_value == '0) && (xyz.z_value == '0))
    else $error("non-zero outputs on an item with a range error");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !xyz.valid)
    else $error("result offered right after reset");

  a_hue_error: assert property (@(posedge clk) disable iff (rst)
    hsl.valid && hsl.ready && (hsl.hue > HUE_FULL) |=> vld[1] && s1_err)
    else $error("out-of-range hue not flagged in the first stage");

endmodule

`default_nettype wire

/* rtl/core/hslxyz_ramp.sv */
// One colour channel of the hue ramp: weighted level between the two HSL levels.
`default_nettype none

module hslxyz_ramp (
  input  logic                 clk,
  input  hslxyz_pkg::ramp_en_t en,
  input  hslxyz_pkg::lvl_t     t1,
  input  hslxyz_pkg::lvl_t     d,
  input  hslxyz_pkg::wgt_t     wgt,
  output hslxyz_pkg::lvl_t     level
);
  import hslxyz_pkg::*;

  logic [PRD_W-1:0]    prod;
  logic [RAMP_Y_W-1:0] y_round;
  logic [RAMP_M_W-1:0] scaled;
  lvl_t                t1_a;
  lvl_t                t1_b;

  // Rounding offset and the division by 256 ahead of the reciprocal multiply.
  assign y_round = RAMP_Y_W'(({1'b0, prod} + (PRD_W + 1)'(HUE_60 / 2)) >> RAMP_SHIFT);

  always_ff @(posedge clk) begin
    if (en.load_prod) begin
      prod <= {{WGT_W{1'b0}}, d} * {{LVL_W{1'b0}}, wgt};
      t1_a <= t1;
    end
    if (en.load_scale) begin
      scaled <= {{RECIP_W{1'b0}}, y_round} * {{RAMP_Y_W{1'b0}}, RECIP15};
      t1_b   <= t1_a;
    end
    if (en.load_level) begin
      level <= t1_b + scaled[RECIP_SHIFT +: LVL_W];
    end
  end

endmodule

`default_nettype wire

/* test/tb_hsl_to_xyz_converter_unit.sv */
// Self-checking testbench for the HSL to CIE XYZ converter pipeline.
`timescale 1ns / 100ps
`default_nettype none

module tb_hsl_to_xyz_converter_unit;
  import hslxyz_pkg::*;

  // Hue landmarks in 1/64 degree units and the Q1.16 unit level.
  localparam longint unsigned TURN     = 23040;
  localparam longint unsigned DEG_60   = 3840;
  localparam longint unsigned DEG_120  = 7680;
  localparam longint unsigned DEG_180  = 11520;
  localparam longint unsigned DEG_240  = 15360;
  localparam longint unsigned UNIT     = 65536;
  localparam longint unsigned SAT_MAX  = 131071;
  localparam int              DRAIN_CYCLES = 16;

  // One converted pixel as it leaves the block.
  typedef struct {
    chan_t x_value;
    chan_t y_value;
    chan_t z_value;
    logic  range_error;
  } xyz_pixel_t;

  logic clk;
  logic rst;

  hslxyz_hsl_if hsl();
  hslxyz_xyz_if xyz();

  hsl_to_xyz_converter_unit dut (
    .clk (clk),
    .rst (rst),
    .hsl (hsl),
    .xyz (xyz)
  );

  // Pixels whose conversion has been predicted but not yet seen at the output.
  xyz_pixel_t pending_xyz[$];
  longint unsigned coef_q [3][3];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The clock runs with a 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A separate watchdog ends a run that has hung, long after any correct run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Coefficient in parts per million, scaled to the matrix fraction width and
  // rounded to nearest with halves up.
  function automatic longint unsigned ppm_to_q(input longint unsigned ppm);
    return ((ppm << FRAC_BITS) + 64'd500000) / 64'd1000000;
  endfunction

  // Level of one channel along the piecewise hue ramp between t1 and t2.
  function automatic longint unsigned hue_ramp(input longint unsigned t1,
                                               input longint unsigned t2,
                                               input longint unsigned a);
    longint unsigned span;
    span = t2 - t1;
    if (a < DEG_60) begin
      return t1 + (span * a + DEG_60 / 2) / DEG_60;
    end
    if (a < DEG_180) begin
      return t2;
    end
    if (a < DEG_240) begin
      return t1 + (span * (DEG_240 - a) + DEG_60 / 2) / DEG_60;
    end
    return t1;
  endfunction

  // Works out the XYZ pixel that the block must produce for one HSL pixel.
  function automatic xyz_pixel_t convert_hsl(input hue_t hue_in, input chan_t sat_in,
                                             input chan_t light_in);
    longint unsigned h;
    longint unsigned s;
    longint unsigned l;
    longint unsigned p;
    longint unsigned t1;
    longint unsigned t2;
    longint unsigned acc;
    longint unsigned lev [3];
    longint unsigned comp [3];
    xyz_pixel_t px;
    h = hue_in;
    s = sat_in;
    l = light_in;
    if (h > TURN || s > UNIT || l > UNIT) begin
      px.x_value = '0;
      px.y_value = '0;
      px.z_value = '0;
      px.range_error = 1'b1;
      return px;
    end
    // A full turn is the same hue as zero degrees.
    if (h == TURN) begin
      h = 0;
    end
    if (s == 0) begin
      lev[0] = l;
      lev[1] = l;
      lev[2] = l;
    end else begin
      p  = (l * s + UNIT / 2) >> 16;
      t2 = (l <= UNIT / 2) ? (l + p) : (l + s - p);
      t1 = (2 * l > t2) ? (2 * l - t2) : 0;
      if (t2 < t1) begin
        t2 = t1;
      end
      lev[0] = hue_ramp(t1, t2, (h + DEG_120) % TURN);
      lev[1] = hue_ramp(t1, t2, h);
      lev[2] = hue_ramp(t1, t2, (h + TURN - DEG_120) % TURN);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc += coef_q[i][j] * lev[j];
      end
      acc = (acc + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      comp[i] = (acc > SAT_MAX) ? SAT_MAX : acc;
    end
    px.x_value = chan_t'(comp[0]);
    px.y_value = chan_t'(comp[1]);
    px.z_value = chan_t'(comp[2]);
    px.range_error = 1'b0;
    return px;
  endfunction

  // Offers one pixel, with random idle cycles ahead of it, and records the
  // expected conversion once the block has accepted it.
  task automatic send_pixel(input hue_t h, input chan_t s, input chan_t l);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      hsl.valid      <= 1'b0;
      hsl.hue        <= hue_t'($urandom);
      hsl.saturation <= chan_t'($urandom);
      hsl.lightness  <= chan_t'($urandom);
      @(negedge clk);
    end
    hsl.valid      <= 1'b1;
    hsl.hue        <= h;
    hsl.saturation <= s;
    hsl.lightness  <= l;
    do @(posedge clk); while (!hsl.ready);
    pending_xyz.push_back(convert_hsl(h, s, l));
  endtask

  // Lowers valid and waits for every outstanding pixel, then lets the
  // pipeline run empty for a while.
  task automatic drain_pipeline();
    @(negedge clk);
    hsl.valid <= 1'b0;
    while (pending_xyz.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Draws one random pixel: mostly well-formed, with boundary values, grey
  // pixels, fields just past their range and completely random fields mixed in.
  task automatic draw_pixel(output hue_t h, output chan_t s, output chan_t l);
    int pick;
    pick = $urandom_range(0, 99);
    h = hue_t'($urandom_range(0, TURN));
    s = chan_t'($urandom_range(0, UNIT));
    l = chan_t'($urandom_range(0, UNIT));
    if (pick < 8) begin
      h = hue_t'($urandom);
      s = chan_t'($urandom);
      l = chan_t'($urandom);
    end else if (pick < 14) begin
      case ($urandom_range(0, 2))
        0: h = hue_t'($urandom_range(TURN + 1, 32767));
        1: s = chan_t'($urandom_range(UNIT + 1, SAT_MAX));
        default: l = chan_t'($urandom_range(UNIT + 1, SAT_MAX));
      endcase
    end else if (pick < 22) begin
      s = '0;
    end else if (pick < 32) begin
      case ($urandom_range(0, 8))
        0: h = hue_t'(0);
        1: h = hue_t'(DEG_60 - 1);
        2: h = hue_t'(DEG_60);
        3: h = hue_t'(DEG_180 - 1);
        4: h = hue_t'(DEG_180);
        5: h = hue_t'(DEG_240 - 1);
        6: h = hue_t'(DEG_240);
        7: h = hue_t'(TURN - 1);
        default: h = hue_t'(TURN);
      endcase
      s = $urandom_range(0, 1) ? chan_t'(UNIT) : chan_t'($urandom_range(0, 3));
      l = chan_t'(UNIT / 2 - 2 + $urandom_range(0, 4));
    end
  endtask

  task automatic send_random_pixels(input int count);
    hue_t h;
    chan_t s;
    chan_t l;
    for (int n = 0; n < count; n++) begin
      draw_pixel(h, s, l);
      send_pixel(h, s, l);
    end
    drain_pipeline();
  endtask

  // Black, white and the lightness boundary where the level formula changes.
  task automatic test_level_extremes();
    send_pixel(hue_t'(0), chan_t'(0), chan_t'(0));
    send_pixel(hue_t'(TURN), chan_t'(UNIT), chan_t'(UNIT));
    send_pixel(hue_t'(DEG_60), chan_t'(UNIT), chan_t'(UNIT / 2));
    send_pixel(hue_t'(DEG_60), chan_t'(UNIT), chan_t'(UNIT / 2 + 1));
    send_pixel(hue_t'(1), chan_t'(1), chan_t'(UNIT - 1));
    drain_pipeline();
  endtask

  // Fully saturated hues on each corner of the ramp, and the full turn.
  task automatic test_primary_hues();
    send_pixel(hue_t'(0), chan_t'(UNIT), chan_t'(UNIT / 2));
    send_pixel(hue_t'(DEG_120), chan_t'(UNIT), chan_t'(UNIT / 2));
    send_pixel(hue_t'(DEG_240), chan_t'(UNIT), chan_t'(UNIT / 2));
    send_pixel(hue_t'(DEG_180), chan_t'(UNIT), chan_t'(UNIT / 2));
    send_pixel(hue_t'(DEG_240 + DEG_60), chan_t'(UNIT), chan_t'(UNIT / 2));
    send_pixel(hue_t'(TURN - 1), chan_t'(UNIT), chan_t'(UNIT / 2));
    send_pixel(hue_t'(TURN), chan_t'(UNIT), chan_t'(UNIT / 2));
    drain_pipeline();
  endtask

  // With no saturation every channel sits at the lightness level.
  task automatic test_grey_pixels();
    send_pixel(hue_t'(5000), chan_t'(0), chan_t'(40000));
    send_pixel(hue_t'(TURN), chan_t'(0), chan_t'(UNIT));
    send_pixel(hue_t'(DEG_120), chan_t'(0), chan_t'(1));
    drain_pipeline();
  endtask

  // Any field beyond its range must flag an error and give zero outputs.
  task automatic test_out_of_range();
    send_pixel(hue_t'(TURN + 1), chan_t'(UNIT), chan_t'(UNIT / 2));
    send_pixel(hue_t'(32767), chan_t'(0), chan_t'(0));
    send_pixel(hue_t'(0), chan_t'(UNIT + 1), chan_t'(UNIT / 2));
    send_pixel(hue_t'(0), chan_t'(SAT_MAX), chan_t'(0));
    send_pixel(hue_t'(0), chan_t'(UNIT), chan_t'(UNIT + 1));
    send_pixel(hue_t'(0), chan_t'(0), chan_t'(SAT_MAX));
    send_pixel(hue_t'(32767), chan_t'(SAT_MAX), chan_t'(SAT_MAX));
    drain_pipeline();
  endtask

  // A receiver that stalls most of the time fills every stage behind it.
  task automatic test_random_slow_receiver();
    send_idle_pct = 6;
    recv_idle_pct = 84;
    send_random_pixels(480);
  endtask

  // A sender with long gaps leaves bubbles travelling down the pipeline.
  task automatic test_random_slow_sender();
    send_idle_pct = 84;
    recv_idle_pct = 6;
    send_random_pixels(480);
  endtask

  // Back-to-back pixels at the full rate of one per cycle.
  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_pixels(480);
  endtask

  // The receiver drops ready at random, in the proportion the current test
  // sets, and changes it only at the falling edge.
  always @(negedge clk) begin
    xyz.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Every item taken from the output is compared with the oldest prediction.
  // Sampling at the rising edge sees the values from before the edge.
  always @(posedge clk) begin
    xyz_pixel_t want;
    if (!rst && xyz.valid && xyz.ready) begin
      if (pending_xyz.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual x=%0d y=%0d z=%0d err=%0b",
                 $time, xyz.x_value, xyz.y_value, xyz.z_value, xyz.range_error);
        mismatch_count++;
      end else begin
        want = pending_xyz.pop_front();
        check_field("x_value", want.x_value, xyz.x_value);
        check_field("y_value", want.y_value, xyz.y_value);
        check_field("z_value", want.z_value, xyz.z_value);
        check_field("range_error", want.range_error, xyz.range_error);
      end
    end
  end

  initial begin
    // All inputs start at known values while reset is held.
    rst            = 1'b1;
    hsl.valid      = 1'b0;
    hsl.hue        = '0;
    hsl.saturation = '0;
    hsl.lightness  = '0;
    xyz.ready      = 1'b0;

    // Matrix rows give X, Y and Z; columns weight R, G and B.
    coef_q[0][0] = ppm_to_q(430574);
    coef_q[0][1] = ppm_to_q(341550);
    coef_q[0][2] = ppm_to_q(178325);
    coef_q[1][0] = ppm_to_q(222015);
    coef_q[1][1] = ppm_to_q(706655);
    coef_q[1][2] = ppm_to_q(71330);
    coef_q[2][0] = ppm_to_q(20183);
    coef_q[2][1] = ppm_to_q(129553);
    coef_q[2][2] = ppm_to_q(939180);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The directed tests run with the sender mostly busy and the receiver
    // mostly stalled, so that the pipeline fills up behind them.
    send_idle_pct = 6;
    recv_idle_pct = 84;
    test_level_extremes();
    test_primary_hues();
    test_grey_pixels();
    test_out_of_range();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/hslxyz_pkg.sv
rtl/core/hslxyz_if.sv
rtl/core/hslxyz_ramp.sv
rtl/core/hsl_to_xyz_converter_unit.sv
test/tb_hsl_to_xyz_converter_unit.sv
